// ===== rtl/shc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_pkg: stepper homing calibrator package
// Request, result and configuration types, phase codes and register indexes.
// ----------------------------------------------------------------------------
package shc_pkg;

   localparam int unsigned HALF_PERIOD_BITS = 16;
   localparam int unsigned MAX_STEPS_BITS   = 20;
   localparam int unsigned TRAVEL_BITS      = 20;
   localparam int unsigned AXIS_BITS        = 2;
   localparam int unsigned CSR_INDEX_BITS   = 2;
   localparam int unsigned CSR_DATA_BITS    = 20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STEPS   = 2'd1;

   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 16'd600;
   localparam logic [MAX_STEPS_BITS-1:0]   MAX_STEPS_RESET   = 20'd4096;

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_HOME_SAMPLE = 3'd1;
   localparam logic [2:0] PH_HOME_STEP   = 3'd2;
   localparam logic [2:0] PH_FAR_SAMPLE  = 3'd3;
   localparam logic [2:0] PH_FAR_STEP    = 3'd4;
   localparam logic [2:0] PH_CENTRE_STEP = 3'd5;

   typedef struct packed {
      logic                 action;
      logic [AXIS_BITS-1:0] axis;
      logic                 far_limit_pressed;
      logic                 home_limit_pressed;
   } req_type;

   typedef struct packed {
      logic                   step_level;
      logic                   forward;
      logic                   drive_enable;
      logic                   busy_res;
      logic                   done_res;
      logic                   failed;
      logic [TRAVEL_BITS-1:0] travel_steps;
      logic [AXIS_BITS-1:0]   axis_now;
   } rsp_type;

   typedef struct packed {
      logic [HALF_PERIOD_BITS-1:0] half_period_ticks;
      logic [MAX_STEPS_BITS-1:0]   max_calibration_steps;
   } cfg_type;

endpackage

// ===== rtl/stepper_homing_calibrator.sv =====
`timescale 1ns / 1ps
// a request's result passes the request register, then the result register, and
// is held there until taken; throughput is one request per cycle while results
// are taken, set by the single-pass sequencer logic
// reset: synchronous, clears phase, counters, axis and all stored travel,
// and loads half period 600 and step limit 4096
// ----------------------------------------------------------------------------
// stepper_homing_calibrator: limit switch homing and travel calibration
// Seeks home, counts travel to the far switch and steps back to the centre.
// ----------------------------------------------------------------------------
module stepper_homing_calibrator #(
   parameter int unsigned AXES            = 3,
   parameter int unsigned STEP_COUNT_BITS = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  shc_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output shc_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [shc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [shc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import shc_pkg::*;

   cfg_type cfg_ff;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_next;
   logic    advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks     <= HALF_PERIOD_RESET;
         cfg_ff.max_calibration_steps <= MAX_STEPS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HALF_PERIOD: begin
               cfg_ff.half_period_ticks <= csr_wdata[HALF_PERIOD_BITS-1:0];
            end
            CSR_MAX_STEPS: begin
               cfg_ff.max_calibration_steps <= csr_wdata[MAX_STEPS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   shc_ctrl #(
      .AXES            (AXES),
      .STEP_COUNT_BITS (STEP_COUNT_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .rsp     (rsp_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   a_done_fail_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.failed))
      else $error("done and failed in the same result");

   a_end_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.done_res || rsp_ff.failed)) |-> !rsp_ff.busy_res)
      else $error("calibration ended but still busy");

   a_forward_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.forward) |-> (rsp_ff.busy_res && rsp_ff.drive_enable))
      else $error("forward seek while not busy");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result lost");

endmodule

// ===== rtl/shc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_ctrl: homing sequencer
// Holds the calibration state and per-axis travel, and works out one result
// per request from the registered request and the current state.
// ----------------------------------------------------------------------------
module shc_ctrl #(
   parameter int unsigned AXES            = 3,
   parameter int unsigned STEP_COUNT_BITS = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  shc_pkg::req_type req,
   input  shc_pkg::cfg_type cfg,
   output shc_pkg::rsp_type rsp
);
   import shc_pkg::*;

   localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int unsigned LW = (STEP_COUNT_BITS > MAX_STEPS_BITS) ?
                                STEP_COUNT_BITS : MAX_STEPS_BITS;
   localparam logic [STEP_COUNT_BITS-1:0] CNT_MASK = '1;

   logic [2:0]                 phase_ff, phase_in;
   logic [AXIS_BITS-1:0]       axis_ff, axis_in;
   logic [STEP_COUNT_BITS-1:0] step_ff, step_in;
   logic [HALF_PERIOD_BITS-1:0] tick_ff, tick_in;
   logic                       pulse_ff, pulse_in;
   logic [STEP_COUNT_BITS-1:0] centre_ff, centre_in;
   logic [STEP_COUNT_BITS-1:0] travel_ff [AXES];

   logic                       store_wr;
   logic [STEP_COUNT_BITS-1:0] store_val;
   logic [AW-1:0]              ax_idx;
   logic [LW-1:0]              limit;
   logic [HALF_PERIOD_BITS:0]  half_period;
   logic [HALF_PERIOD_BITS:0]  tick_next;
   logic                       level, done, fail;

   assign ax_idx = AW'(axis_ff);

   // step limit is the lower of the register and the counter's top value; a zero half period acts as 1
   always_comb begin
      if (LW'(cfg.max_calibration_steps) > LW'(CNT_MASK)) begin
         limit = LW'(CNT_MASK);
      end else begin
         limit = LW'(cfg.max_calibration_steps);
      end
      if (cfg.half_period_ticks == '0) begin
         half_period = (HALF_PERIOD_BITS+1)'(1);
      end else begin
         half_period = {1'b0, cfg.half_period_ticks};
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      axis_in   = axis_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      pulse_in  = pulse_ff;
      centre_in = centre_ff;
      store_wr  = 1'b0;
      store_val = step_ff;
      level     = 1'b0;
      done      = 1'b0;
      fail      = 1'b0;
      tick_next = '0;

      if (req.action == ACTION_START) begin
         if (phase_ff == PH_IDLE && (32'(req.axis) < AXES)) begin
            axis_in   = req.axis;
            step_in   = '0;
            centre_in = '0;
            phase_in  = PH_HOME_SAMPLE;
            pulse_in  = 1'b0;
            tick_in   = '0;
         end
      end else begin
         // sample ticks: far switch wins over home
         if (phase_ff == PH_HOME_SAMPLE) begin
            if (req.home_limit_pressed && !req.far_limit_pressed) begin
               phase_in = PH_FAR_SAMPLE;
               step_in  = '0;
            end else begin
               phase_in = PH_HOME_STEP;
               pulse_in = 1'b1;
               tick_in  = '0;
            end
         end else if (phase_ff == PH_FAR_SAMPLE) begin
            if (req.far_limit_pressed) begin
               store_wr  = 1'b1;
               store_val = step_ff;
               centre_in = step_ff >> 1;
               if ((step_ff >> 1) == '0) begin
                  phase_in = PH_IDLE;
                  pulse_in = 1'b0;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_CENTRE_STEP;
                  pulse_in = 1'b1;
                  tick_in  = '0;
               end
            end else begin
               phase_in = PH_FAR_STEP;
               pulse_in = 1'b1;
               tick_in  = '0;
            end
         end

         if (phase_in == PH_HOME_STEP || phase_in == PH_FAR_STEP ||
             phase_in == PH_CENTRE_STEP) begin
            level     = pulse_in;
            tick_next = {1'b0, tick_in} + (HALF_PERIOD_BITS+1)'(1);
            if (tick_next >= half_period) begin
               tick_in = '0;
               if (pulse_in) begin
                  pulse_in = 1'b0;
               end else if (phase_in == PH_HOME_STEP || phase_in == PH_FAR_STEP) begin
                  if (LW'(step_in) >= limit) begin
                     phase_in = PH_IDLE;
                     pulse_in = 1'b0;
                     fail     = 1'b1;
                  end else begin
                     step_in  = step_in + STEP_COUNT_BITS'(1);
                     phase_in = (phase_in == PH_HOME_STEP) ? PH_HOME_SAMPLE
                                                            : PH_FAR_SAMPLE;
                  end
               end else begin
                  centre_in = centre_in - STEP_COUNT_BITS'(1);
                  if (centre_in == '0) begin
                     phase_in = PH_IDLE;
                     pulse_in = 1'b0;
                     done     = 1'b1;
                  end else begin
                     pulse_in = 1'b1;
                  end
               end
            end else begin
               tick_in = tick_next[HALF_PERIOD_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp.step_level   = level;
      rsp.forward      = (phase_in == PH_FAR_SAMPLE || phase_in == PH_FAR_STEP);
      rsp.drive_enable = (phase_in != PH_IDLE);
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.done_res     = done;
      rsp.failed       = fail;
      rsp.axis_now     = axis_in;
      // the written travel is visible in the same result
      if (store_wr) begin
         rsp.travel_steps = TRAVEL_BITS'(store_val);
      end else begin
         rsp.travel_steps = TRAVEL_BITS'(travel_ff[AW'(axis_in)]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         axis_ff   <= '0;
         step_ff   <= '0;
         tick_ff   <= '0;
         pulse_ff  <= 1'b0;
         centre_ff <= '0;
         for (int i = 0; i < AXES; i++) begin
            travel_ff[i] <= '0;
         end
      end else if (step_en) begin
         phase_ff  <= phase_in;
         axis_ff   <= axis_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         pulse_ff  <= pulse_in;
         centre_ff <= centre_in;
         if (store_wr) begin
            travel_ff[ax_idx] <= store_val;
         end
      end
   end

endmodule

// ===== bench/stepper_homing_calibrator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_homing_calibrator_test: homing calibrator bench
// Drives timer ticks and start requests through the request channel, predicts
// every status result in step with the block and checks each field. Directed
// tests cover idle ticks, ignored starts, zero travel, step limit overruns and
// a full centre run. Randomised switch traffic then runs under several idling
// and stall mixes.
// ----------------------------------------------------------------------------
module stepper_homing_calibrator_test;
   import shc_pkg::*;

   localparam int unsigned AXES            = 3;
   localparam int unsigned RANDOM_REQUESTS = 1750;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned SEQUENCE_TICKS  = 400;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   req_type                   req_data         = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata        = '0;

   always #5 clock = ~clock;

   stepper_homing_calibrator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // statuses still owed by the block, oldest first
   rsp_type status_queue[$];

   // predicted calibrator state
   logic [HALF_PERIOD_BITS-1:0] half_period = HALF_PERIOD_RESET;
   logic [MAX_STEPS_BITS-1:0]   step_limit  = MAX_STEPS_RESET;
   logic [2:0]                  phase_now   = PH_IDLE;
   logic [AXIS_BITS-1:0]        axis_sel    = '0;
   logic [TRAVEL_BITS-1:0]      steps_taken = '0;
   int unsigned                 ticks_in_half = 0;
   logic                        pulse_high  = 1'b0;
   logic [TRAVEL_BITS-1:0]      centre_left = '0;
   logic [TRAVEL_BITS-1:0]      travel_mem [AXES];

   int unsigned idle_pct     = 0;
   int unsigned stall_pct    = 0;
   int unsigned accepted     = 0;
   int unsigned results_seen = 0;
   int unsigned done_seen    = 0;
   int unsigned fail_seen    = 0;
   int unsigned errors       = 0;

   function automatic void start_pulse(input logic [2:0] next_phase);
      phase_now     = next_phase;
      pulse_high    = 1'b1;
      ticks_in_half = 0;
   endfunction

   function automatic void park();
      phase_now     = PH_IDLE;
      pulse_high    = 1'b0;
      ticks_in_half = 0;
   endfunction

   function automatic rsp_type advance_homing(input req_type r);
      rsp_type     s;
      int unsigned hp;
      logic        level;
      logic        done;
      logic        fail;
      level = 1'b0;
      done  = 1'b0;
      fail  = 1'b0;
      if (r.action == ACTION_START) begin
         if (phase_now == PH_IDLE && r.axis < AXES) begin
            axis_sel      = r.axis;
            steps_taken   = '0;
            centre_left   = '0;
            phase_now     = PH_HOME_SAMPLE;
            pulse_high    = 1'b0;
            ticks_in_half = 0;
         end
      end else begin
         // far switch wins, so home only counts with far released
         if (phase_now == PH_HOME_SAMPLE) begin
            if (r.home_limit_pressed && !r.far_limit_pressed) begin
               phase_now   = PH_FAR_SAMPLE;
               steps_taken = '0;
            end else begin
               start_pulse(PH_HOME_STEP);
            end
         end else if (phase_now == PH_FAR_SAMPLE) begin
            if (r.far_limit_pressed) begin
               travel_mem[axis_sel] = steps_taken;
               centre_left          = steps_taken >> 1;
               if (centre_left == 0) begin
                  park();
                  done = 1'b1;
               end else begin
                  start_pulse(PH_CENTRE_STEP);
               end
            end else begin
               start_pulse(PH_FAR_STEP);
            end
         end
         if (phase_now == PH_HOME_STEP || phase_now == PH_FAR_STEP ||
             phase_now == PH_CENTRE_STEP) begin
            hp    = (half_period == 0) ? 1 : half_period;
            level = pulse_high;
            ticks_in_half++;
            if (ticks_in_half >= hp) begin
               ticks_in_half = 0;
               if (pulse_high) begin
                  pulse_high = 1'b0;
               end else if (phase_now != PH_CENTRE_STEP) begin
                  // end of a seek step: limit reached means this was one too many
                  if (steps_taken >= step_limit) begin
                     park();
                     fail = 1'b1;
                  end else begin
                     steps_taken++;
                     phase_now = (phase_now == PH_HOME_STEP) ? PH_HOME_SAMPLE
                                                             : PH_FAR_SAMPLE;
                  end
               end else begin
                  centre_left--;
                  if (centre_left == 0) begin
                     park();
                     done = 1'b1;
                  end else begin
                     pulse_high = 1'b1;
                  end
               end
            end
         end
      end
      s.step_level   = level;
      s.forward      = (phase_now == PH_FAR_SAMPLE || phase_now == PH_FAR_STEP);
      s.drive_enable = (phase_now != PH_IDLE);
      s.busy_res     = (phase_now != PH_IDLE);
      s.done_res     = done;
      s.failed       = fail;
      s.travel_steps = travel_mem[axis_sel];
      s.axis_now     = axis_sel;
      return s;
   endfunction

   task automatic send_request(input logic action, input logic [AXIS_BITS-1:0] axis,
                               input logic far, input logic home);
      req_type r;
      r.action             = action;
      r.axis               = axis;
      r.far_limit_pressed  = far;
      r.home_limit_pressed = home;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      status_queue.push_back(advance_homing(r));
      accepted++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= data;
      @(posedge clock);
      if (index == CSR_HALF_PERIOD)
         half_period = data[HALF_PERIOD_BITS-1:0];
      else if (index == CSR_MAX_STEPS)
         step_limit = data[MAX_STEPS_BITS-1:0];
   endtask

   // drive any running calibration to its end with helpful switch levels
   task automatic finish_calibration();
      while (phase_now != PH_IDLE)
         send_request(ACTION_TICK, AXIS_BITS'($urandom_range(3)),
                      phase_now == PH_FAR_SAMPLE || phase_now == PH_FAR_STEP,
                      phase_now == PH_HOME_SAMPLE || phase_now == PH_HOME_STEP);
   endtask

   task automatic configure(input logic [HALF_PERIOD_BITS-1:0] hp,
                            input logic [MAX_STEPS_BITS-1:0] limit, input logic spare);
      finish_calibration();
      settle();
      if (spare)
         csr_write($urandom_range(1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                   CSR_DATA_BITS'($urandom));
      csr_write(CSR_HALF_PERIOD, CSR_DATA_BITS'(hp));
      csr_write(CSR_MAX_STEPS, CSR_DATA_BITS'(limit));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [19:0] want,
                                         input logic [19:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (status_queue.size() == 0) begin
            $error("status result with no request outstanding");
            errors++;
         end else begin
            want = status_queue.pop_front();
            compare_field("step_level", TRAVEL_BITS'(want.step_level),
                          TRAVEL_BITS'(rsp_data.step_level));
            compare_field("forward", TRAVEL_BITS'(want.forward),
                          TRAVEL_BITS'(rsp_data.forward));
            compare_field("drive_enable", TRAVEL_BITS'(want.drive_enable),
                          TRAVEL_BITS'(rsp_data.drive_enable));
            compare_field("busy_res", TRAVEL_BITS'(want.busy_res),
                          TRAVEL_BITS'(rsp_data.busy_res));
            compare_field("done_res", TRAVEL_BITS'(want.done_res),
                          TRAVEL_BITS'(rsp_data.done_res));
            compare_field("failed", TRAVEL_BITS'(want.failed),
                          TRAVEL_BITS'(rsp_data.failed));
            compare_field("travel_steps", want.travel_steps, rsp_data.travel_steps);
            compare_field("axis_now", TRAVEL_BITS'(want.axis_now),
                          TRAVEL_BITS'(rsp_data.axis_now));
            if (want.done_res) done_seen++;
            if (want.failed) fail_seen++;
         end
      end
   end

   task automatic test_idle_requests();
      for (int i = 0; i < 4; i++)
         send_request(ACTION_TICK, i[1:0], i[1], i[0]);
      // no such axis, so the start is dropped
      send_request(ACTION_START, 2'd3, 1'b1, 1'b1);
   endtask

   task automatic test_zero_travel();
      configure('1, '1, 1'b0);
      send_request(ACTION_START, 2'd2, 1'b0, 1'b0);
      send_request(ACTION_TICK, 2'd0, 1'b0, 1'b1);
      send_request(ACTION_TICK, 2'd0, 1'b1, 1'b1);
   endtask

   task automatic test_zero_limit();
      configure('0, '0, 1'b0);
      send_request(ACTION_START, 2'd1, 1'b1, 1'b0);
      // both pressed: far has priority, so the home seek steps once and overruns
      send_request(ACTION_TICK, 2'd0, 1'b1, 1'b1);
      send_request(ACTION_TICK, 2'd0, 1'b1, 1'b1);
   endtask

   task automatic test_single_step_travel();
      configure(16'd1, 20'd1, 1'b1);
      send_request(ACTION_START, 2'd0, 1'b0, 1'b1);
      send_request(ACTION_TICK, 2'd3, 1'b0, 1'b1);
      send_request(ACTION_TICK, 2'd3, 1'b0, 1'b0);
      send_request(ACTION_TICK, 2'd3, 1'b0, 1'b0);
      // start while busy is ignored
      send_request(ACTION_START, 2'd1, 1'b0, 1'b0);
      send_request(ACTION_TICK, 2'd3, 1'b1, 1'b0);
   endtask

   task automatic test_far_overrun();
      send_request(ACTION_START, 2'd1, 1'b0, 1'b0);
      send_request(ACTION_TICK, 2'd2, 1'b0, 1'b1);
      while (phase_now != PH_IDLE)
         send_request(ACTION_TICK, 2'd2, 1'b0, 1'b0);
   endtask

   task automatic test_centre_run();
      logic paused;
      paused = 1'b0;
      configure(16'd1, 20'd20, 1'b0);
      send_request(ACTION_START, 2'd2, 1'b0, 1'b0);
      while (phase_now != PH_IDLE) begin
         // hold requests back mid-seek until the block has caught up
         if (!paused && phase_now == PH_FAR_SAMPLE && steps_taken == 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         send_request(ACTION_TICK, 2'd1,
                      phase_now == PH_FAR_SAMPLE && steps_taken >= 4,
                      phase_now == PH_HOME_SAMPLE && steps_taken >= 1);
      end
   endtask

   task automatic run_calibration_sequence();
      int unsigned home_pct;
      int unsigned far_pct;
      int unsigned ticks;
      home_pct = $urandom_range(50, 5);
      far_pct  = $urandom_range(40, 3);
      send_request(ACTION_START, AXIS_BITS'($urandom_range(AXES - 1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      ticks = 0;
      while (phase_now != PH_IDLE && ticks < SEQUENCE_TICKS) begin
         if ($urandom_range(29) == 0)
            send_request(ACTION_START, AXIS_BITS'($urandom_range(3)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         else
            send_request(ACTION_TICK, AXIS_BITS'($urandom_range(3)),
                         $urandom_range(99) < far_pct, $urandom_range(99) < home_pct);
         ticks++;
      end
   endtask

   task automatic randomise_registers();
      logic [HALF_PERIOD_BITS-1:0] hp;
      logic [MAX_STEPS_BITS-1:0]   limit;
      case ($urandom_range(9))
         0:       hp = '0;
         8, 9:    hp = HALF_PERIOD_BITS'($urandom_range(8, 4));
         default: hp = HALF_PERIOD_BITS'($urandom_range(3, 1));
      endcase
      case ($urandom_range(9))
         7, 8:    limit = MAX_STEPS_BITS'($urandom_range(1048575, 41));
         9:       limit = '1;
         default: limit = MAX_STEPS_BITS'($urandom_range(40));
      endcase
      configure(hp, limit, $urandom_range(5) == 0);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                      input int unsigned stall);
      int unsigned first;
      idle_pct  = idle;
      stall_pct = stall;
      first     = accepted;
      while (accepted - first < count) begin
         if ($urandom_range(4) == 0) randomise_registers();
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(12, 4))
               send_request($urandom_range(3) == 0, AXIS_BITS'($urandom_range(3)),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
         else
            run_calibration_sequence();
      end
   endtask

   initial begin
      foreach (travel_mem[i]) travel_mem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_idle_requests();
      test_zero_travel();
      test_zero_limit();
      test_single_step_travel();
      test_far_overrun();
      test_centre_run();
      test_random_traffic(RANDOM_REQUESTS / 4, 0, 0);
      test_random_traffic(RANDOM_REQUESTS / 4, 77, 0);
      test_random_traffic(RANDOM_REQUESTS / 4, 0, 77);
      test_random_traffic(RANDOM_REQUESTS / 4, 21, 21);
      finish_calibration();
      settle();
      $display("%0d requests sent, %0d status results checked", accepted, results_seen);
      $display("%0d calibrations completed, %0d step limit overruns", done_seen, fail_seen);
      if (errors == 0 && status_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
